### rtl/core/tfwp_pkg.sv
// Shared types and constants for the tape frame / 36-bit word packer.
// No dependencies; imported by every module under rtl/core.
package tfwp_pkg;

  localparam int WORD_W  = 36;
  localparam int FRAME_W = 8;
  localparam int COUNT_W = 16;
  localparam int POS_W   = 3;

  // frames per word in each format
  localparam logic [POS_W-1:0] LEN_CORE_DUMP = 3'd5;
  localparam logic [POS_W-1:0] LEN_PLAIN     = 3'd4;

  // reset value of the format register
  localparam logic FMT_RESET = 1'b1;

  // result kinds
  localparam logic KIND_WORD  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  typedef enum logic [1:0] {
    REQ_READ_FWD = 2'd0,
    REQ_READ_REV = 2'd1,
    REQ_WRITE    = 2'd2,
    REQ_LOAD     = 2'd3
  } req_t;

  // one result item
  typedef struct packed {
    logic               kind;
    logic [WORD_W-1:0]  word;
    logic [FRAME_W-1:0] frame;
    logic               done;
    logic               err;
    logic               last;
  } result_t;

  // hand-off from the request decoder to the frame splitter
  typedef struct packed {
    logic               start;
    logic [WORD_W-1:0]  word;
    logic [POS_W-1:0]   last_idx;
    logic               wrap;
  } wstart_t;

endpackage

### rtl/core/tfwp_outq.sv
// Two-entry result queue: output register plus skid entry.
// Depends on tfwp_pkg.
module tfwp_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tfwp_pkg::result_t push_data,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_stall,
  output tfwp_pkg::result_t head
);
  import tfwp_pkg::*;

  logic [1:0] count;
  result_t    skid;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != 2'd0);
  assign can_push  = (count != 2'd2);

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // payload moves: head refills from skid, or from push when skid empty
  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        head <= skid;
        if (push) begin
          skid <= push_data;
        end
      end else if (push) begin
        head <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        head <= push_data;
      end else begin
        skid <= push_data;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != 2'd2) || pop)
    else $error("push into full result queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result queue count out of range");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && !push && count == 2'd1) |=> !out_valid)
    else $error("result queue did not drain");

endmodule

### rtl/core/tfwp_split.sv
// Frame splitter: emits the frames of one written word, one per cycle while the result queue has room.
// Depends on tfwp_pkg.
module tfwp_split (
  input  logic              clk,
  input  logic              rst,
  input  tfwp_pkg::wstart_t wstart,
  input  logic              can_push,
  output logic              busy,
  output logic              push,
  output tfwp_pkg::result_t push_data
);
  import tfwp_pkg::*;

  logic [WORD_W-1:0]  word;
  logic [POS_W-1:0]   idx;
  logic [POS_W-1:0]   last_idx;
  logic               wrap;
  logic [FRAME_W-1:0] frame;
  logic               final_frame;

  assign push        = busy && can_push;
  assign final_frame = (idx == last_idx);

  // pick frame idx, most significant byte first, nibble in the fifth
  always_comb begin
    case (idx)
      3'd0:    frame = word[35:28];
      3'd1:    frame = word[27:20];
      3'd2:    frame = word[19:12];
      3'd3:    frame = word[11:4];
      default: frame = {4'b0, word[3:0]};
    endcase
  end

  always_comb begin
    push_data.kind  = KIND_FRAME;
    push_data.word  = '0;
    push_data.frame = frame;
    push_data.done  = final_frame && wrap;
    push_data.err   = 1'b0;
    push_data.last  = final_frame;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (wstart.start) begin
      busy <= 1'b1;
    end else if (push && final_frame) begin
      busy <= 1'b0;
    end
  end

  // payload and frame index
  always_ff @(posedge clk) begin
    if (wstart.start) begin
      word     <= wstart.word;
      last_idx <= wstart.last_idx;
      wrap     <= wstart.wrap;
      idx      <= '0;
    end else if (push) begin
      idx <= idx + 3'd1;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    wstart.start |-> !busy)
    else $error("write started while splitting");
  a_end_burst: assert property (@(posedge clk) disable iff (rst)
    (push && final_frame && !wstart.start) |=> !busy)
    else $error("splitter stayed busy after final frame");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= last_idx)
    else $error("frame index beyond burst length");

endmodule

### rtl/core/tfwp_pack.sv
// Request decoder and packer: holds the format, assembly word, position and
// frame count; packs read frames and sizes write bursts. Depends on tfwp_pkg.
module tfwp_pack (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic                         cfg_data,
  input  logic                         accept,
  input  logic [1:0]                   req_type,
  input  logic [tfwp_pkg::FRAME_W-1:0] frame_in,
  input  logic                         record_end,
  input  logic [tfwp_pkg::WORD_W-1:0]  word_in,
  input  logic [tfwp_pkg::COUNT_W-1:0] count_value,
  output logic                         push,
  output tfwp_pkg::result_t            push_data,
  output tfwp_pkg::wstart_t            wstart
);
  import tfwp_pkg::*;

  logic                 core_dump_format;
  logic [WORD_W-1:0]    assembly_word;
  logic [POS_W-1:0]     frame_position;
  logic [COUNT_W-1:0]   frame_counter;

  logic [WORD_W-1:0]    assembly_word_next;
  logic [POS_W-1:0]     frame_position_next;
  logic [COUNT_W-1:0]   frame_counter_next;

  req_t                 req;
  logic                 reverse;
  logic [POS_W-1:0]     len;
  logic [POS_W-1:0]     pos_sat;
  logic [POS_W-1:0]     slot;
  logic [POS_W-1:0]     pos_inc;
  logic [WORD_W-1:0]    contrib;
  logic [WORD_W-1:0]    packed_word;
  logic [COUNT_W-1:0]   count_inc;
  logic                 word_full;
  logic [COUNT_W:0]     wrap_dist;
  logic                 wrap_hit;
  logic [POS_W-1:0]     burst_len;

  assign req     = req_t'(req_type);
  assign reverse = (req == REQ_READ_REV);
  assign len     = core_dump_format ? LEN_CORE_DUMP : LEN_PLAIN;

  // read slot from the shared position, saturated after a format change
  assign pos_sat = (frame_position >= len) ? len - 3'd1 : frame_position;
  assign slot    = reverse ? len - 3'd1 - pos_sat : pos_sat;
  assign pos_inc = pos_sat + 3'd1;

  always_comb begin
    case (slot)
      3'd0:    contrib = {frame_in, 28'b0};
      3'd1:    contrib = {8'b0, frame_in, 20'b0};
      3'd2:    contrib = {16'b0, frame_in, 12'b0};
      3'd3:    contrib = {24'b0, frame_in, 4'b0};
      default: contrib = {32'b0, frame_in[3:0]};
    endcase
  end

  assign packed_word = assembly_word | contrib;
  assign count_inc   = frame_counter + 16'd1;
  assign word_full   = (pos_inc >= len);

  // write burst: frames until the count wraps, capped at the word length
  assign wrap_dist = {1'b1, {COUNT_W{1'b0}}} - {1'b0, frame_counter};
  assign wrap_hit  = (wrap_dist <= {{(COUNT_W+1-POS_W){1'b0}}, len});
  assign burst_len = wrap_hit ? wrap_dist[POS_W-1:0] : len;

  always_comb begin
    assembly_word_next  = assembly_word;
    frame_position_next = frame_position;
    frame_counter_next  = frame_counter;
    push                = 1'b0;
    push_data.kind      = KIND_WORD;
    push_data.word      = packed_word;
    push_data.frame     = '0;
    push_data.done      = record_end;
    push_data.err       = record_end && !reverse && (count_inc != '0);
    push_data.last      = 1'b1;
    wstart.start        = 1'b0;
    wstart.word         = word_in;
    wstart.last_idx     = burst_len - 3'd1;
    wstart.wrap         = wrap_hit;
    if (accept) begin
      case (req)
        REQ_READ_FWD, REQ_READ_REV: begin
          frame_counter_next = count_inc;
          if (word_full || record_end) begin
            push                = 1'b1;
            assembly_word_next  = '0;
            frame_position_next = '0;
          end else begin
            assembly_word_next  = packed_word;
            frame_position_next = pos_inc;
          end
        end
        REQ_WRITE: begin
          if (frame_counter != '0) begin
            wstart.start       = 1'b1;
            frame_counter_next = frame_counter + {{(COUNT_W-POS_W){1'b0}}, burst_len};
          end
        end
        REQ_LOAD: begin
          frame_counter_next  = count_value;
          assembly_word_next  = '0;
          frame_position_next = '0;
        end
        default: begin
          frame_counter_next = frame_counter;
        end
      endcase
    end
  end

  // format register
  always_ff @(posedge clk) begin
    if (rst) begin
      core_dump_format <= FMT_RESET;
    end else if (cfg_write) begin
      core_dump_format <= cfg_data;
    end
  end

  // packer state
  always_ff @(posedge clk) begin
    if (rst) begin
      assembly_word  <= '0;
      frame_position <= '0;
      frame_counter  <= '0;
    end else begin
      assembly_word  <= assembly_word_next;
      frame_position <= frame_position_next;
      frame_counter  <= frame_counter_next;
    end
  end

  a_one_source: assert property (@(posedge clk) disable iff (rst)
    !(push && wstart.start))
    else $error("read result and write burst in one cycle");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    frame_position < LEN_CORE_DUMP)
    else $error("frame position out of range");
  a_burst_nonzero: assert property (@(posedge clk) disable iff (rst)
    wstart.start |-> (burst_len != '0) && (burst_len <= len))
    else $error("bad write burst length");

endmodule

### rtl/core/tape_frame_word_packer_unit.sv
// Tape frame / 36-bit word packer, top level.
// Read and load requests: one per cycle while in_stall is low; a word result is
// registered and ready in the cycle after the frame that completes it. Writes: the
// splitter emits one frame per cycle while the queue has room; requests stall meanwhile.
// Synchronous active-high reset clears state, counter and result queue; the
// format register resets to core-dump (five frames per word).
module tape_frame_word_packer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  frame_in,
  input  logic        record_end,
  input  logic [35:0] word_in,
  input  logic [15:0] count_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [35:0] word_out,
  output logic [7:0]  frame_out,
  output logic        record_done,
  output logic        count_error,
  output logic        last
);
  import tfwp_pkg::*;

  logic    accept;
  logic    can_push;
  logic    busy;
  logic    rd_push;
  result_t rd_data;
  logic    wr_push;
  result_t wr_data;
  wstart_t wstart;
  logic    q_push;
  result_t q_data;
  result_t head;

  // stall only from registered state
  assign in_stall = busy || !can_push;
  assign accept   = in_valid && !in_stall;

  tfwp_pack u_pack (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .req_type    (req_type),
    .frame_in    (frame_in),
    .record_end  (record_end),
    .word_in     (word_in),
    .count_value (count_value),
    .push        (rd_push),
    .push_data   (rd_data),
    .wstart      (wstart)
  );

  tfwp_split u_split (
    .clk       (clk),
    .rst       (rst),
    .wstart    (wstart),
    .can_push  (can_push),
    .busy      (busy),
    .push      (wr_push),
    .push_data (wr_data)
  );

  // the two sources never push in the same cycle
  assign q_push = rd_push || wr_push;
  assign q_data = wr_push ? wr_data : rd_data;

  tfwp_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign kind        = head.kind;
  assign word_out    = head.word;
  assign frame_out   = head.frame;
  assign record_done = head.done;
  assign count_error = head.err;
  assign last        = head.last;

endmodule

### dv/tape_frame_word_packer_unit_test.sv
// Self-checking testbench for tape_frame_word_packer_unit: frame packing, word splitting,
// frame-count tracking and format changes, checked against a predictor in the scoreboard.
// Depends on tfwp_pkg and the tape_frame_word_packer_unit RTL only.
module tape_frame_word_packer_unit_test;
  import tfwp_pkg::*;

  // Predicts the packer's results and checks what the block returns
  class tape_packer_scoreboard;
    bit                 fmt = FMT_RESET;
    bit [WORD_W-1:0]    asm_word;
    bit [POS_W-1:0]     pos;
    bit [COUNT_W-1:0]   frame_count;
    result_t            expected_q[$];
    int                 errors;

    function int pending();
      return expected_q.size();
    endfunction

    function void set_format(bit f);
      fmt = f;
    endfunction

    function int unsigned frames_per_word();
      return fmt ? LEN_CORE_DUMP : LEN_PLAIN;
    endfunction

    function void flag_error(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    // one read frame; a word leaves when full or at record end
    function void pack_frame(bit rev, bit [FRAME_W-1:0] frame, bit rec_end);
      int unsigned len, p, slot;
      result_t r;
      len = frames_per_word();
      p = pos;
      // a format change can leave the position past the new word length
      if (p >= len) p = len - 1;
      slot = rev ? len - 1 - p : p;
      if (slot >= 4) asm_word[3:0] = asm_word[3:0] | frame[3:0];
      else asm_word = asm_word | (WORD_W'(frame) << (8 * (3 - slot) + 4));
      frame_count = frame_count + 1'b1;
      p++;
      if (p >= len || rec_end) begin
        r = '0;
        r.kind = KIND_WORD;
        r.word = asm_word;
        r.done = rec_end;
        r.err  = rec_end && !rev && frame_count != 0;
        r.last = 1'b1;
        expected_q.push_back(r);
        asm_word = '0;
        p = 0;
      end
      pos = POS_W'(p);
    endfunction

    // one write word; stops at the frame where the count wraps
    function void split_word(bit [WORD_W-1:0] word);
      int unsigned len;
      result_t r;
      int tail;
      if (frame_count == 0) return;
      len = frames_per_word();
      for (int i = 0; i < len; i++) begin
        r = '0;
        r.kind  = KIND_FRAME;
        r.frame = (i >= 4) ? {4'd0, word[3:0]} : word[8 * (3 - i) + 4 +: 8];
        frame_count = frame_count + 1'b1;
        r.done = (frame_count == 0);
        expected_q.push_back(r);
        if (frame_count == 0) break;
      end
      tail = expected_q.size() - 1;
      expected_q[tail].last = 1'b1;
    endfunction

    // accepted request
    function void note_request(req_t req, bit [FRAME_W-1:0] frame, bit rec_end,
                               bit [WORD_W-1:0] word, bit [COUNT_W-1:0] count);
      case (req)
        REQ_READ_FWD: pack_frame(1'b0, frame, rec_end);
        REQ_READ_REV: pack_frame(1'b1, frame, rec_end);
        REQ_WRITE:    split_word(word);
        default: begin
          frame_count = count;
          asm_word = '0;
          pos = '0;
        end
      endcase
    endfunction

    // accepted result against the oldest expectation
    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        flag_error($sformatf({"unexpected result: kind=%0d word=%h frame=%h ",
                              "done=%0d err=%0d last=%0d"},
                             got.kind, got.word, got.frame, got.done, got.err, got.last));
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.word !== want.word || got.frame !== want.frame ||
          got.done !== want.done || got.err !== want.err || got.last !== want.last)
        flag_error($sformatf({"mismatch: expected kind=%0d word=%h frame=%h done=%0d ",
                              "err=%0d last=%0d, got kind=%0d word=%h frame=%h done=%0d ",
                              "err=%0d last=%0d"},
                             want.kind, want.word, want.frame, want.done, want.err,
                             want.last, got.kind, got.word, got.frame, got.done, got.err,
                             got.last));
    endfunction
  endclass

  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 80;
  localparam int SETTLE     = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  req_t        req_type = REQ_LOAD;
  logic [7:0]  frame_in = '0;
  logic        record_end = 1'b0;
  logic [35:0] word_in = '0;
  logic [15:0] count_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [35:0] word_out;
  logic [7:0]  frame_out;
  logic        record_done;
  logic        count_error;
  logic        last;

  bit      rush;
  bit      hold_long;
  int      idle_cycles;
  int      items_sent;
  result_t seen;
  tape_packer_scoreboard sb = new();

  tape_frame_word_packer_unit dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type), .frame_in(frame_in),
    .record_end(record_end), .word_in(word_in), .count_value(count_value),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .word_out(word_out),
    .frame_out(frame_out), .record_done(record_done), .count_error(count_error),
    .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen.kind  = kind;
      seen.word  = word_out;
      seen.frame = frame_out;
      seen.done  = record_done;
      seen.err   = count_error;
      seen.last  = last;
      sb.check_result(seen);
    end
  end

  // watchdog: cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // receiver stall, drawn per result; one long hold on request
  initial begin
    int n;
    while (rst) @(posedge clk);
    forever begin
      if (hold_long) begin
        n = LONG_HOLD;
        hold_long = 1'b0;
      end else begin
        n = rush ? 0 : $urandom_range(0, 5);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic bit [35:0] rand_word();
    return {4'($urandom_range(0, 15)), 32'($urandom)};
  endfunction

  // offer one request after a random gap and wait for it to be taken
  task automatic send_request(req_t req, bit [7:0] frame, bit rec_end, bit [35:0] word,
                              bit [15:0] count);
    int gap;
    gap = rush ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    frame_in    <= frame;
    record_end  <= rec_end;
    word_in     <= word;
    count_value <= count;
    do @(posedge clk); while (in_stall);
    // a write with no open record is dropped by the block
    if (!(req == REQ_WRITE && sb.frame_count == 0)) items_sent++;
    sb.note_request(req, frame, rec_end, word, count);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_format(bit f);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data  <= f;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_format(f);
  endtask

  // load a count, usually minus the frame total, then read the frames with the end on the last
  task automatic read_record();
    int nframes;
    bit [15:0] count;
    req_t dir;
    bit mixed;
    nframes = $urandom_range(1, 16);
    count = 16'(0 - nframes);
    if ($urandom_range(0, 3) == 0) count = 16'($urandom);
    dir = $urandom_range(0, 1) ? REQ_READ_REV : REQ_READ_FWD;
    mixed = ($urandom_range(0, 7) == 0);
    send_request(REQ_LOAD, 8'($urandom), 1'($urandom), rand_word(), count);
    for (int i = 0; i < nframes; i++) begin
      if (mixed) dir = $urandom_range(0, 1) ? REQ_READ_REV : REQ_READ_FWD;
      send_request(dir, 8'($urandom), i == nframes - 1, rand_word(), 16'($urandom));
    end
  endtask

  // load a count, then write words until it wraps (sometimes one extra)
  task automatic write_record();
    int nframes;
    bit [15:0] count;
    nframes = $urandom_range(1, 14);
    count = 16'(0 - nframes);
    if ($urandom_range(0, 5) == 0) count = 16'($urandom);
    send_request(REQ_LOAD, 8'($urandom), 1'($urandom), rand_word(), count);
    repeat ((nframes + 3) / 4 + $urandom_range(0, 1))
      send_request(REQ_WRITE, 8'($urandom), 1'($urandom), rand_word(), 16'($urandom));
  endtask

  task automatic random_phase(int n_items);
    int target;
    int sel;
    target = items_sent + n_items;
    while (items_sent < target) begin
      sel = $urandom_range(0, 9);
      if (sel <= 5) read_record();
      else if (sel <= 7) write_record();
      else send_request(req_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                        rand_word(), 16'($urandom));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // core-dump format: one full forward word, then a reverse record ending at count zero
    send_request(REQ_LOAD, 8'h00, 1'b0, 36'h0, 16'hFFF6);
    send_request(REQ_READ_FWD, 8'hFF, 1'b0, 36'h0, 16'h0);
    send_request(REQ_READ_FWD, 8'h00, 1'b0, 36'h0, 16'h0);
    send_request(REQ_READ_FWD, 8'hA5, 1'b0, 36'h0, 16'h0);
    send_request(REQ_READ_FWD, 8'h5A, 1'b0, 36'h0, 16'h0);
    send_request(REQ_READ_FWD, 8'hFF, 1'b0, 36'h0, 16'h0);
    send_request(REQ_READ_REV, 8'h12, 1'b0, 36'h0, 16'h0);
    send_request(REQ_READ_REV, 8'h34, 1'b0, 36'h0, 16'h0);
    send_request(REQ_READ_REV, 8'h56, 1'b0, 36'h0, 16'h0);
    send_request(REQ_READ_REV, 8'h78, 1'b0, 36'h0, 16'h0);
    send_request(REQ_READ_REV, 8'h9A, 1'b1, 36'h0, 16'h0);
    // count wraps mid-word, then a write with no open record
    send_request(REQ_LOAD, 8'hFF, 1'b1, 36'hFFFFFFFFF, 16'hFFFE);
    send_request(REQ_WRITE, 8'h00, 1'b0, 36'hFFFFFFFFF, 16'hFFFF);
    send_request(REQ_WRITE, 8'hFF, 1'b1, 36'h000000000, 16'h0000);
    // forward record end with count left over
    send_request(REQ_LOAD, 8'h00, 1'b0, 36'h0, 16'h8000);
    send_request(REQ_READ_FWD, 8'h3C, 1'b1, 36'h0, 16'h0);
    // mixed directions inside one word
    send_request(REQ_READ_FWD, 8'h81, 1'b0, 36'h0, 16'h0);
    send_request(REQ_READ_REV, 8'h7E, 1'b0, 36'h0, 16'h0);
    send_request(REQ_READ_FWD, 8'h42, 1'b0, 36'h0, 16'h0);
    send_request(REQ_READ_FWD, 8'hC3, 1'b0, 36'h0, 16'h0);
    // switch to four frames with four already packed: position saturates
    set_format(1'b0);
    send_request(REQ_READ_REV, 8'h99, 1'b0, 36'h0, 16'h0);
    send_request(REQ_LOAD, 8'h00, 1'b0, 36'h0, 16'hFFF0);
    send_request(REQ_WRITE, 8'h00, 1'b0, 36'h123456789, 16'h0);

    // random phases across both formats; one with no gaps and a long receiver hold
    random_phase(90);
    set_format(1'b1);
    rush = 1'b1;
    hold_long = 1'b1;
    random_phase(90);
    rush = 1'b0;
    set_format(1'b0);
    random_phase(90);
    set_format(1'b1);
    random_phase(90);

    // drain and let any stray result show up
    wait_idle();
    if (sb.pending() != 0)
      sb.flag_error($sformatf("%0d expected results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
